@@ rtl/wffcs_pkg.sv @@
// ----------------------------------------------------------------------------
// wffcs_pkg
// Shared types, constants and the CRC-32 byte update for the 802.11 frame
// FCS checker and station classifier.
// ----------------------------------------------------------------------------
package wffcs_pkg;

	// Reflected CRC-32 polynomial and start value.
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Reset values of the configuration registers.
	localparam logic [15:0] MIN_CAPTURE_RESET  = 16'd39;
	localparam logic [15:0] MIN_RADIOTAP_RESET = 16'd15;
	localparam logic [15:0] MAX_RADIOTAP_RESET = 16'd50;
	localparam logic [15:0] MIN_MAC_RESET      = 16'd14;

	// Smallest MAC start: the radiotap preamble occupies bytes 0 to 3.
	localparam logic [15:0] HDR_BYTES = 16'd4;
	localparam logic [15:0] FCS_BYTES = 16'd4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_MIN_CAPTURE  = 2'd0,
		CFG_MIN_RADIOTAP = 2'd1,
		CFG_MAX_RADIOTAP = 2'd2,
		CFG_MIN_MAC      = 2'd3
	} cfg_index_t;

	// Result classification codes.
	typedef enum logic [2:0] {
		CLS_CORRUPT   = 3'd0,
		CLS_CONTROL   = 3'd1,
		CLS_DATA_EXCL = 3'd2,
		CLS_STATION   = 3'd3,
		CLS_UNDEF     = 3'd4
	} frame_class_t;

	// 802.11 frame type codes.
	typedef enum logic [1:0] {
		FT_MGMT     = 2'd0,
		FT_CTRL     = 2'd1,
		FT_DATA     = 2'd2,
		FT_RESERVED = 2'd3
	} frame_type_t;

	// Which address names the station.
	typedef enum logic [1:0] {
		CH_NONE  = 2'd0,
		CH_ADDR1 = 2'd1,
		CH_ADDR2 = 2'd2
	} addr_choice_t;

	typedef addr_choice_t mgmt_table_t [16];
	typedef addr_choice_t ds_table_t [4];

	// Station address choice per management subtype.
	localparam mgmt_table_t MGMT_CHOICE = '{
		CH_ADDR2, CH_ADDR1, CH_ADDR2, CH_ADDR1, CH_ADDR2, CH_ADDR1, CH_NONE,  CH_NONE,
		CH_ADDR1, CH_ADDR1, CH_ADDR2, CH_ADDR2, CH_ADDR2, CH_ADDR2, CH_NONE,  CH_NONE
	};

	// Station address choice per toDS/fromDS code of a data frame.
	localparam ds_table_t DS_CHOICE = '{CH_NONE, CH_ADDR2, CH_ADDR1, CH_NONE};

	// One byte of the reflected CRC-32, bit by bit.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/wifi_frame_fcs_station_classifier_top.sv @@
// ----------------------------------------------------------------------------
// wifi_frame_fcs_station_classifier_top
// Checks the FCS of captured 802.11 frames with a radiotap header, one byte
// per word, and classifies the transmitting or receiving station.
// ----------------------------------------------------------------------------
// Datapath: a byte word is registered in the input register, then processed;
// the result of a frame is loaded from there into the result register.
// Throughput: one byte per cycle while a held result does not stall the byte channel.
// Reset: arst_n clears the frame state, the word valid flags and loads the
// configuration registers with their default bounds.
module wifi_frame_fcs_station_classifier_top
	import wffcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	// Byte channel.
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,

	// Result channel.
	output logic        result_valid,
	input  logic        result_stall,
	output logic        fcs_ok,
	output logic [2:0]  frame_class,
	output logic [47:0] station_address,
	output logic [15:0] frame_bytes,

	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [15:0] min_capture_q, min_radiotap_q, max_radiotap_q, min_mac_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Frame state.
	logic [15:0] byte_count_q;
	logic [15:0] rt_len_q;
	logic [31:0] crc_q;
	logic [7:0]  fcs_dl_q [4];
	logic [7:0]  fc_low_q, fc_high_q;
	logic [47:0] addr1_q, addr2_q;
	logic        overflow_q;

	// Next frame state.
	logic [15:0] nx_count;
	logic [15:0] nx_rt_len;
	logic [31:0] nx_crc;
	logic [7:0]  nx_dl [4];
	logic [7:0]  nx_fc_low, nx_fc_high;
	logic [47:0] nx_addr1, nx_addr2;
	logic        nx_overflow;

	// Result register.
	logic        res_valid_q;
	logic        res_ok_q;
	logic [2:0]  res_class_q;
	logic [47:0] res_addr_q;
	logic [15:0] res_bytes_q;

	logic        adv;
	logic [15:0] mac_start, mac_idx, mac_len;
	logic        frame_ok;
	frame_class_t cls;
	logic [47:0] cls_addr;
	logic [31:0] fcs_word;
	frame_type_t ftype;
	addr_choice_t choice;

	// The pipe moves whenever the result register is free or being taken.
	assign adv        = !res_valid_q || !result_stall;
	assign byte_stall = valid_s1 && !adv;
	assign cfg_ready  = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_capture_q  <= MIN_CAPTURE_RESET;
			min_radiotap_q <= MIN_RADIOTAP_RESET;
			max_radiotap_q <= MAX_RADIOTAP_RESET;
			min_mac_q      <= MIN_MAC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_MIN_CAPTURE:  min_capture_q  <= cfg_data;
				CFG_MIN_RADIOTAP: min_radiotap_q <= cfg_data;
				CFG_MAX_RADIOTAP: max_radiotap_q <= cfg_data;
				CFG_MIN_MAC:      min_mac_q      <= cfg_data;
				default:          min_mac_q      <= min_mac_q;
			endcase
		end
	end

	// Input word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Byte update of the frame state.
	always_comb begin
		nx_count    = byte_count_q;
		nx_rt_len   = rt_len_q;
		nx_crc      = crc_q;
		nx_dl       = fcs_dl_q;
		nx_fc_low   = fc_low_q;
		nx_fc_high  = fc_high_q;
		nx_addr1    = addr1_q;
		nx_addr2    = addr2_q;
		nx_overflow = overflow_q;
		mac_start   = (rt_len_q < HDR_BYTES) ? HDR_BYTES : rt_len_q;
		mac_idx     = byte_count_q - mac_start;
		if (overflow_q || byte_count_q == 16'hFFFF) begin
			nx_overflow = 1'b1;
		end else begin
			nx_count = byte_count_q + 16'd1;
			if (byte_count_q == 16'd2) begin
				nx_rt_len[7:0] = byte_s1;
			end
			if (byte_count_q == 16'd3) begin
				nx_rt_len[15:8] = byte_s1;
			end
			if (byte_count_q >= HDR_BYTES && byte_count_q >= mac_start) begin
				if (mac_idx == 16'd0) begin
					nx_fc_low = byte_s1;
				end else if (mac_idx == 16'd1) begin
					nx_fc_high = byte_s1;
				end else if (mac_idx >= 16'd4 && mac_idx <= 16'd9) begin
					nx_addr1 = {addr1_q[39:0], byte_s1};
				end else if (mac_idx >= 16'd10 && mac_idx <= 16'd15) begin
					nx_addr2 = {addr2_q[39:0], byte_s1};
				end
				nx_dl[3] = fcs_dl_q[2];
				nx_dl[2] = fcs_dl_q[1];
				nx_dl[1] = fcs_dl_q[0];
				nx_dl[0] = byte_s1;
				if (mac_idx >= 16'd4) begin
					nx_crc = crc_byte(crc_q, fcs_dl_q[3]);
				end
			end
		end
	end

	// Length bounds and FCS compare on the updated state.
	always_comb begin
		mac_len  = nx_count - nx_rt_len;
		fcs_word = {nx_dl[0], nx_dl[1], nx_dl[2], nx_dl[3]};
		frame_ok = !nx_overflow
			&& !(nx_count < min_capture_q)
			&& !(nx_rt_len > max_radiotap_q) && !(nx_rt_len < min_radiotap_q)
			&& !(nx_rt_len < HDR_BYTES) && !(nx_count < nx_rt_len)
			&& !(mac_len < min_mac_q) && !(mac_len < FCS_BYTES)
			&& (~nx_crc == fcs_word);
	end

	// Station classification.
	always_comb begin
		ftype    = frame_type_t'(nx_fc_low[3:2]);
		choice   = CH_NONE;
		cls      = CLS_CORRUPT;
		cls_addr = 48'd0;
		case (ftype)
			FT_MGMT: choice = MGMT_CHOICE[nx_fc_low[7:4]];
			FT_DATA: choice = DS_CHOICE[nx_fc_high[1:0]];
			default: choice = CH_NONE;
		endcase
		if (frame_ok) begin
			if (ftype == FT_CTRL) begin
				cls = CLS_CONTROL;
			end else if (ftype == FT_DATA &&
					(nx_fc_high[1:0] == 2'd0 || nx_fc_high[1:0] == 2'd3)) begin
				cls = CLS_DATA_EXCL;
			end else begin
				case (choice)
					CH_ADDR1: begin
						cls      = CLS_STATION;
						cls_addr = nx_addr1;
					end
					CH_ADDR2: begin
						cls      = CLS_STATION;
						cls_addr = nx_addr2;
					end
					default: cls = CLS_UNDEF;
				endcase
			end
		end
	end

	// Frame state registers; the last byte of a frame clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 16'd0;
			rt_len_q     <= 16'd0;
			crc_q        <= CRC_INIT;
			fcs_dl_q     <= '{default: 8'd0};
			fc_low_q     <= 8'd0;
			fc_high_q    <= 8'd0;
			addr1_q      <= 48'd0;
			addr2_q      <= 48'd0;
			overflow_q   <= 1'b0;
		end else if (valid_s1 && adv) begin
			if (last_s1) begin
				byte_count_q <= 16'd0;
				rt_len_q     <= 16'd0;
				crc_q        <= CRC_INIT;
				fcs_dl_q     <= '{default: 8'd0};
				fc_low_q     <= 8'd0;
				fc_high_q    <= 8'd0;
				addr1_q      <= 48'd0;
				addr2_q      <= 48'd0;
				overflow_q   <= 1'b0;
			end else begin
				byte_count_q <= nx_count;
				rt_len_q     <= nx_rt_len;
				crc_q        <= nx_crc;
				fcs_dl_q     <= nx_dl;
				fc_low_q     <= nx_fc_low;
				fc_high_q    <= nx_fc_high;
				addr1_q      <= nx_addr1;
				addr2_q      <= nx_addr2;
				overflow_q   <= nx_overflow;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			res_ok_q    <= frame_ok;
			res_class_q <= cls;
			res_addr_q  <= cls_addr;
			res_bytes_q <= nx_overflow ? 16'hFFFF : nx_count;
		end
	end

	assign result_valid    = res_valid_q;
	assign fcs_ok          = res_ok_q;
	assign frame_class     = res_class_q;
	assign station_address = res_addr_q;
	assign frame_bytes     = res_bytes_q;

	// A stalled byte word only waits behind a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && res_valid_q && result_stall))
		else $error("byte word stalled without a held result");

	// The end of a frame leaves the frame state cleared.
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && adv) |=> (byte_count_q == 16'd0 && crc_q == CRC_INIT
			&& !overflow_q))
		else $error("frame state not cleared after last byte");

	// An fcs_ok result never reports a corrupt frame, and a failed one reports nothing else.
	a_ok_class: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_ok_q == (res_class_q != CLS_CORRUPT)))
		else $error("fcs_ok disagrees with frame_class");

	// Only a found station carries an address.
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_class_q != CLS_STATION) |-> (res_addr_q == 48'd0))
		else $error("station address set without a found station");

endmodule
